// File: rtl/ssp_pkg.sv
// shared types and constants for the split-step phase rotator
`timescale 1ns / 1ps

package ssp_pkg;

    // fractional guard bits carried through the rotation cells
    localparam int GUARD_BITS = 24;

    // width of the residual angle inside the rotation cells (turns, Q0.32 plus headroom)
    localparam int ANGLE_WIDTH = 34;

    // one radian in Q0.32 turns
    localparam logic [29:0] TURNS_PER_RAD = 30'd683565276;

    // inverse of the limit rotation gain, Q0.32
    localparam logic [31:0] GAIN_INV = 32'h9B74_EDA8;

    // time step values after reset
    localparam logic [31:0] LINEAR_STEP_RESET    = 32'd2147484;
    localparam logic [31:0] NONLINEAR_STEP_RESET = 32'd4294967;

    // arctangent of 2^-i in Q0.32 turns
    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
        32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
        32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
    };

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_LINEAR_STEP    = 1'b0,
        CFG_NONLINEAR_STEP = 1'b1
    } cfg_index_t;

    // quarter turn taken exactly before the rotation cells
    typedef enum logic [1:0] {
        QUARTER_0 = 2'd0,
        QUARTER_1 = 2'd1,
        QUARTER_2 = 2'd2,
        QUARTER_3 = 2'd3
    } quarter_t;

    // time steps handed to the phase generator
    typedef struct packed {
        logic [31:0] linear_time_step;
        logic [31:0] nonlinear_time_step;
    } step_cfg_t;

endpackage

// File: rtl/ssp_phase_gen.sv
// pipelined phase generator: rotation angle in Q0.32 turns from mode, sample and wave number
`timescale 1ns / 1ps

module ssp_phase_gen #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  ssp_pkg::step_cfg_t             step_cfg,
    input  logic                           in_valid,
    input  logic                           mode,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_real,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_imag,
    input  logic        [23:0]             wave_number_sq,
    output logic                           phase_valid,
    output logic        [31:0]             phase,
    output logic signed [SAMPLE_WIDTH-1:0] phase_real,
    output logic signed [SAMPLE_WIDTH-1:0] phase_imag
);

    localparam int STAGES     = 8;
    localparam int SQW        = 2 * SAMPLE_WIDTH;
    localparam int SHIFT_DIFF = 2 * SAMPLE_WIDTH - 32;

    // request tracking and payload carried alongside the arithmetic
    logic                           valid_pipe_reg [STAGES];
    logic                           mode_pipe_reg  [STAGES];
    logic signed [SAMPLE_WIDTH-1:0] re_pipe_reg    [STAGES];
    logic signed [SAMPLE_WIDTH-1:0] im_pipe_reg    [STAGES];
    logic        [23:0]             k2_pipe_reg    [4];
    logic                           neg_pipe_reg   [4];

    // stage 1: squares
    logic signed [SQW-1:0] sqr_prod;
    logic signed [SQW-1:0] sqi_prod;
    logic        [SQW-1:0] sqr_next, sqr_reg;
    logic        [SQW-1:0] sqi_next, sqi_reg;

    // stage 2: intensity in Q6.26
    logic [SQW-1:0] sq_sum;
    logic [31:0]    i26_next, i26_reg;

    // stage 3: intensity squared
    logic [63:0] isq_next, isq_reg;
    logic [31:0] lin_next, lin_reg;

    // stage 4: magnitude of I - I^2 in Q.32
    logic [63:0] lin_wide;
    logic        neg_next;
    logic [63:0] diff;
    logic [63:0] diff_rnd;
    logic [42:0] mag_next, mag_reg;

    // stage 5: angle in radians, partial products
    logic [42:0] rad_operand;
    logic [31:0] step_sel;
    logic [53:0] rpl_next, rpl_reg;
    logic [52:0] rph_next, rph_reg;

    // stage 6: angle in radians, Q.32
    logic [74:0] rad_prod;
    logic [42:0] rad_next, rad_reg;

    // stage 7: turns, partial products
    logic [51:0] tpl_next, tpl_reg;
    logic [50:0] tph_next, tph_reg;

    // stage 8: phase in turns with sign
    logic [72:0] turn_prod;
    logic [31:0] turns;
    logic        negate;
    logic [31:0] phase_next, phase_reg;

    assign sqr_prod = sample_real * sample_real;
    assign sqi_prod = sample_imag * sample_imag;
    assign sqr_next = sqr_prod;
    assign sqi_next = sqi_prod;

    // intensity rescale to Q6.26 with rounding
    assign sq_sum = sqr_reg + sqi_reg;
    generate
        if (SHIFT_DIFF > 0) begin : g_shift_down
            logic [SQW-1:0] sum_rnd;
            assign sum_rnd  = sq_sum + (SQW'(1) << (SHIFT_DIFF - 1));
            assign i26_next = sum_rnd[SHIFT_DIFF+31:SHIFT_DIFF];
        end
        else if (SHIFT_DIFF == 0) begin : g_shift_none
            assign i26_next = sq_sum;
        end
        else begin : g_shift_up
            assign i26_next = {sq_sum, {(-SHIFT_DIFF){1'b0}}};
        end
    endgenerate

    assign isq_next = i26_reg * i26_reg;
    assign lin_next = i26_reg;

    // cubic minus quintic term, rounded to Q.32
    always_comb
    begin
        lin_wide = {6'b0, lin_reg, 26'b0};
        neg_next = isq_reg > lin_wide;
        diff     = neg_next ? (isq_reg - lin_wide) : (lin_wide - isq_reg);
        diff_rnd = diff + (64'd1 << 19);
        mag_next = diff_rnd[62:20];
    end

    // shared step multiply, split in two partial products
    always_comb
    begin
        rad_operand = mode_pipe_reg[3] ? mag_reg : {3'b0, k2_pipe_reg[3], 16'b0};
        step_sel    = mode_pipe_reg[3] ? step_cfg.nonlinear_time_step
                                       : step_cfg.linear_time_step;
        rpl_next    = rad_operand[21:0] * step_sel;
        rph_next    = rad_operand[42:22] * step_sel;
    end

    // radians, round half up
    always_comb
    begin
        rad_prod = {rph_reg, 22'b0} + 75'(rpl_reg);
        rad_next = rad_prod[74:32] + 43'(rad_prod[31]);
    end

    assign tpl_next = rad_reg[21:0] * ssp_pkg::TURNS_PER_RAD;
    assign tph_next = rad_reg[42:22] * ssp_pkg::TURNS_PER_RAD;

    // turns, wrapped to one revolution; linear mode always turns backwards
    always_comb
    begin
        turn_prod  = {tph_reg, 22'b0} + 73'(tpl_reg);
        turns      = turn_prod[63:32] + 32'(turn_prod[31]);
        negate     = mode_pipe_reg[6] ? neg_pipe_reg[3] : 1'b1;
        phase_next = negate ? (32'd0 - turns) : turns;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < STAGES; i++) begin
                valid_pipe_reg[i] <= 1'b0;
            end
        end
        else if (advance) begin
            valid_pipe_reg[0] <= in_valid;
            for (int i = 1; i < STAGES; i++) begin
                valid_pipe_reg[i] <= valid_pipe_reg[i-1];
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (advance) begin
            mode_pipe_reg[0] <= mode;
            re_pipe_reg[0]   <= sample_real;
            im_pipe_reg[0]   <= sample_imag;
            for (int i = 1; i < STAGES; i++) begin
                mode_pipe_reg[i] <= mode_pipe_reg[i-1];
                re_pipe_reg[i]   <= re_pipe_reg[i-1];
                im_pipe_reg[i]   <= im_pipe_reg[i-1];
            end
            k2_pipe_reg[0] <= wave_number_sq;
            for (int i = 1; i < 4; i++) begin
                k2_pipe_reg[i] <= k2_pipe_reg[i-1];
            end
            neg_pipe_reg[0] <= neg_next;
            for (int i = 1; i < 4; i++) begin
                neg_pipe_reg[i] <= neg_pipe_reg[i-1];
            end
            sqr_reg   <= sqr_next;
            sqi_reg   <= sqi_next;
            i26_reg   <= i26_next;
            isq_reg   <= isq_next;
            lin_reg   <= lin_next;
            mag_reg   <= mag_next;
            rpl_reg   <= rpl_next;
            rph_reg   <= rph_next;
            rad_reg   <= rad_next;
            tpl_reg   <= tpl_next;
            tph_reg   <= tph_next;
            phase_reg <= phase_next;
        end
    end

    assign phase_valid = valid_pipe_reg[STAGES-1];
    assign phase       = phase_reg;
    assign phase_real  = re_pipe_reg[STAGES-1];
    assign phase_imag  = im_pipe_reg[STAGES-1];

endmodule

// File: rtl/ssp_rot_cell.sv
// one rotation cell: a single shift-and-add micro-rotation with its own register
`timescale 1ns / 1ps

module ssp_rot_cell #(
    parameter int VALUE_WIDTH = 51,
    parameter int STAGE       = 0
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    advance,
    input  logic                                    valid_in,
    input  logic signed [VALUE_WIDTH-1:0]           x_in,
    input  logic signed [VALUE_WIDTH-1:0]           y_in,
    input  logic signed [ssp_pkg::ANGLE_WIDTH-1:0]  z_in,
    output logic                                    valid_out,
    output logic signed [VALUE_WIDTH-1:0]           x_out,
    output logic signed [VALUE_WIDTH-1:0]           y_out,
    output logic signed [ssp_pkg::ANGLE_WIDTH-1:0]  z_out
);

    localparam logic signed [ssp_pkg::ANGLE_WIDTH-1:0] ATAN_STEP =
        $signed({{(ssp_pkg::ANGLE_WIDTH-32){1'b0}}, ssp_pkg::ATAN_TURNS[STAGE]});

    logic                                   valid_reg;
    logic signed [VALUE_WIDTH-1:0]          x_next, x_reg;
    logic signed [VALUE_WIDTH-1:0]          y_next, y_reg;
    logic signed [ssp_pkg::ANGLE_WIDTH-1:0] z_next, z_reg;
    logic signed [VALUE_WIDTH-1:0]          dx;
    logic signed [VALUE_WIDTH-1:0]          dy;

    // rotate towards zero residual angle
    always_comb
    begin
        dx = y_in >>> STAGE;
        dy = x_in >>> STAGE;
        if (!z_in[ssp_pkg::ANGLE_WIDTH-1]) begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ATAN_STEP;
        end
        else begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ATAN_STEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (advance) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign valid_out = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;

endmodule

// File: rtl/ssp_gain_sat.sv
// gain compensation, guard bit removal and saturation for one rotated component
`timescale 1ns / 1ps

module ssp_gain_sat #(
    parameter int SAMPLE_WIDTH = 24,
    parameter int VALUE_WIDTH  = 51
) (
    input  logic                           clk,
    input  logic                           advance,
    input  logic signed [VALUE_WIDTH-1:0]  value,
    output logic signed [SAMPLE_WIDTH-1:0] result
);

    localparam int LO_WIDTH = VALUE_WIDTH / 2;
    localparam int HI_WIDTH = VALUE_WIDTH - LO_WIDTH;
    localparam int RW       = VALUE_WIDTH + 1 - ssp_pkg::GUARD_BITS;

    localparam logic [VALUE_WIDTH:0] ROUND_HALF = (VALUE_WIDTH+1)'(1) << (ssp_pkg::GUARD_BITS - 1);
    localparam logic [RW-1:0]        NEG_LIMIT  = RW'(1) << (SAMPLE_WIDTH - 1);
    localparam logic [RW-1:0]        POS_LIMIT  = NEG_LIMIT - RW'(1);

    logic                          neg_reg [3];
    logic [VALUE_WIDTH-1:0]        mag_next, mag_reg;
    logic [LO_WIDTH+31:0]          pl_next, pl_reg;
    logic [HI_WIDTH+31:0]          ph_next, ph_reg;
    logic [VALUE_WIDTH+31:0]       prod;
    logic [VALUE_WIDTH-1:0]        scaled_next, scaled_reg;
    logic [VALUE_WIDTH:0]          scaled_rnd;
    logic [RW-1:0]                 rounded;
    logic signed [SAMPLE_WIDTH-1:0] result_next, result_reg;

    // sign and magnitude
    assign mag_next = value[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - value) : value;

    // gain multiply in two halves
    assign pl_next = mag_reg[LO_WIDTH-1:0] * ssp_pkg::GAIN_INV;
    assign ph_next = mag_reg[VALUE_WIDTH-1:LO_WIDTH] * ssp_pkg::GAIN_INV;

    // recombine, round half up to the guard bit scale
    always_comb
    begin
        prod        = {ph_reg, {LO_WIDTH{1'b0}}} + (VALUE_WIDTH+32)'(pl_reg);
        scaled_next = prod[VALUE_WIDTH+31:32] + VALUE_WIDTH'(prod[31]);
    end

    // drop guard bits (half away from zero) and clamp to the sample range
    always_comb
    begin
        scaled_rnd = (VALUE_WIDTH+1)'(scaled_reg) + ROUND_HALF;
        rounded    = scaled_rnd[VALUE_WIDTH:ssp_pkg::GUARD_BITS];
        if (!neg_reg[2]) begin
            if (rounded > POS_LIMIT) begin
                result_next = POS_LIMIT[SAMPLE_WIDTH-1:0];
            end
            else begin
                result_next = rounded[SAMPLE_WIDTH-1:0];
            end
        end
        else begin
            if (rounded > NEG_LIMIT) begin
                result_next = NEG_LIMIT[SAMPLE_WIDTH-1:0];
            end
            else begin
                result_next = SAMPLE_WIDTH'(0) - rounded[SAMPLE_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            neg_reg[0] <= value[VALUE_WIDTH-1];
            neg_reg[1] <= neg_reg[0];
            neg_reg[2] <= neg_reg[1];
            mag_reg    <= mag_next;
            pl_reg     <= pl_next;
            ph_reg     <= ph_next;
            scaled_reg <= scaled_next;
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// File: rtl/split_step_phase_rotator.sv
// split-step phase rotator: top level with configuration, rotation chain and output skid
//
// Usage: one request per cycle on the input channel (in_valid / in_stall) carries mode,
// one complex sample and a squared wave number; each request gives exactly one rotated
// sample on the output channel (out_valid / out_stall), in order.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0 is the linear
// time step, index 1 the nonlinear one. cfg_ready is always high; write only while idle.
// Pipeline: 8 phase generation stages, a quarter-turn stage, one rotation cell per
// stage (20 by default), four gain and saturation stages, then the output register.
// Throughput: one request per cycle while in_stall is low; all stages move in step.
// Stall: when out_stall holds a result, the next finished result parks in a one-entry
// skid register; while that entry is full in_stall is high and the pipeline holds, so
// nothing is dropped. in_stall comes from a register only.
// Reset: clears all valid bits and the skid entry and loads the default time steps.
`timescale 1ns / 1ps

module split_step_phase_rotator #(
    parameter int SAMPLE_WIDTH    = 24,
    parameter int ROTATION_STAGES = 20
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [0:0]                     cfg_index,
    input  logic [31:0]                    cfg_data,
    // input channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           mode,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_real,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_imag,
    input  logic        [23:0]             wave_number_sq,
    // output channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] rotated_real,
    output logic signed [SAMPLE_WIDTH-1:0] rotated_imag
);

    localparam int XW = SAMPLE_WIDTH + ssp_pkg::GUARD_BITS + 3;
    localparam int ZW = ssp_pkg::ANGLE_WIDTH;

    // configuration registers
    logic [31:0]        linear_step_reg;
    logic [31:0]        nonlinear_step_reg;
    ssp_pkg::step_cfg_t step_cfg;

    // pipeline control
    logic advance;

    // phase generator outputs
    logic                           phase_valid;
    logic [31:0]                    phase;
    logic signed [SAMPLE_WIDTH-1:0] phase_real;
    logic signed [SAMPLE_WIDTH-1:0] phase_imag;

    // quarter-turn stage
    logic [31:0]                    phase_bias;
    ssp_pkg::quarter_t              quarter;
    logic [31:0]                    residual;
    logic signed [XW-1:0]           re_wide;
    logic signed [XW-1:0]           im_wide;
    logic signed [XW-1:0]           x0_next;
    logic signed [XW-1:0]           y0_next;
    logic signed [ZW-1:0]           z0_next;
    logic                           valid0_reg;
    logic signed [XW-1:0]           x0_reg;
    logic signed [XW-1:0]           y0_reg;
    logic signed [ZW-1:0]           z0_reg;

    // rotation chain taps
    logic                 valid_chain [ROTATION_STAGES+1];
    logic signed [XW-1:0] x_chain     [ROTATION_STAGES+1];
    logic signed [XW-1:0] y_chain     [ROTATION_STAGES+1];
    logic signed [ZW-1:0] z_chain     [ROTATION_STAGES+1];

    // finishing stages
    logic [3:0]                     fin_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] fin_real;
    logic signed [SAMPLE_WIDTH-1:0] fin_imag;
    logic                           arriving;

    // output register and skid entry
    logic                           out_free;
    logic                           out_valid_next, out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_real_next, out_real_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_imag_next, out_imag_reg;
    logic                           skid_valid_next, skid_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] skid_real_reg;
    logic signed [SAMPLE_WIDTH-1:0] skid_imag_reg;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            linear_step_reg    <= ssp_pkg::LINEAR_STEP_RESET;
            nonlinear_step_reg <= ssp_pkg::NONLINEAR_STEP_RESET;
        end
        else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                ssp_pkg::CFG_LINEAR_STEP:    linear_step_reg    <= cfg_data;
                ssp_pkg::CFG_NONLINEAR_STEP: nonlinear_step_reg <= cfg_data;
                default:                     linear_step_reg    <= linear_step_reg;
            endcase
        end
    end

    assign step_cfg.linear_time_step    = linear_step_reg;
    assign step_cfg.nonlinear_time_step = nonlinear_step_reg;

    // the pipeline moves whenever the skid entry is free
    assign advance  = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    ssp_phase_gen #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_phase_gen (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .step_cfg       (step_cfg),
        .in_valid       (in_valid),
        .mode           (mode),
        .sample_real    (sample_real),
        .sample_imag    (sample_imag),
        .wave_number_sq (wave_number_sq),
        .phase_valid    (phase_valid),
        .phase          (phase),
        .phase_real     (phase_real),
        .phase_imag     (phase_imag)
    );

    // exact quarter turn, residual within an eighth of a turn
    always_comb
    begin
        phase_bias = phase + 32'h2000_0000;
        quarter    = ssp_pkg::quarter_t'(phase_bias[31:30]);
        residual   = phase - {phase_bias[31:30], 30'b0};
        z0_next    = ZW'($signed(residual));
        re_wide    = {{(XW-SAMPLE_WIDTH-ssp_pkg::GUARD_BITS){phase_real[SAMPLE_WIDTH-1]}},
                      phase_real, {ssp_pkg::GUARD_BITS{1'b0}}};
        im_wide    = {{(XW-SAMPLE_WIDTH-ssp_pkg::GUARD_BITS){phase_imag[SAMPLE_WIDTH-1]}},
                      phase_imag, {ssp_pkg::GUARD_BITS{1'b0}}};
        unique case (quarter)
            ssp_pkg::QUARTER_1: begin
                x0_next = XW'(0) - im_wide;
                y0_next = re_wide;
            end
            ssp_pkg::QUARTER_2: begin
                x0_next = XW'(0) - re_wide;
                y0_next = XW'(0) - im_wide;
            end
            ssp_pkg::QUARTER_3: begin
                x0_next = im_wide;
                y0_next = XW'(0) - re_wide;
            end
            default: begin
                x0_next = re_wide;
                y0_next = im_wide;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid0_reg <= 1'b0;
        end
        else if (advance) begin
            valid0_reg <= phase_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            x0_reg <= x0_next;
            y0_reg <= y0_next;
            z0_reg <= z0_next;
        end
    end

    assign valid_chain[0] = valid0_reg;
    assign x_chain[0]     = x0_reg;
    assign y_chain[0]     = y0_reg;
    assign z_chain[0]     = z0_reg;

    // row of rotation cells
    generate
        for (genvar i = 0; i < ROTATION_STAGES; i++) begin : g_cell
            ssp_rot_cell #(
                .VALUE_WIDTH (XW),
                .STAGE       (i)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .advance   (advance),
                .valid_in  (valid_chain[i]),
                .x_in      (x_chain[i]),
                .y_in      (y_chain[i]),
                .z_in      (z_chain[i]),
                .valid_out (valid_chain[i+1]),
                .x_out     (x_chain[i+1]),
                .y_out     (y_chain[i+1]),
                .z_out     (z_chain[i+1])
            );
        end
    endgenerate

    // gain compensation and saturation, both components
    ssp_gain_sat #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .VALUE_WIDTH  (XW)
    ) u_gain_real (
        .clk     (clk),
        .advance (advance),
        .value   (x_chain[ROTATION_STAGES]),
        .result  (fin_real)
    );

    ssp_gain_sat #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .VALUE_WIDTH  (XW)
    ) u_gain_imag (
        .clk     (clk),
        .advance (advance),
        .value   (y_chain[ROTATION_STAGES]),
        .result  (fin_imag)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fin_valid_reg <= '0;
        end
        else if (advance) begin
            fin_valid_reg <= {fin_valid_reg[2:0], valid_chain[ROTATION_STAGES]};
        end
    end

    assign arriving = advance && fin_valid_reg[3];

    // output register with one skid entry
    always_comb
    begin
        out_free        = !out_valid_reg || !out_stall;
        out_valid_next  = out_valid_reg;
        out_real_next   = out_real_reg;
        out_imag_next   = out_imag_reg;
        skid_valid_next = skid_valid_reg;
        if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_real_next   = skid_real_reg;
                out_imag_next   = skid_imag_reg;
                skid_valid_next = 1'b0;
            end
            else begin
                out_valid_next = arriving;
                out_real_next  = fin_real;
                out_imag_next  = fin_imag;
            end
        end
        else if (arriving) begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_real_reg <= out_real_next;
        out_imag_reg <= out_imag_next;
        if (!out_free && arriving) begin
            skid_real_reg <= fin_real;
            skid_imag_reg <= fin_imag;
        end
    end

    assign out_valid    = out_valid_reg;
    assign rotated_real = out_real_reg;
    assign rotated_imag = out_imag_reg;

    // the skid entry only fills behind a held result
    a_skid_behind_output: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry full with no result on the output");

    // a result arriving at a held output is parked, not lost
    a_arrival_parked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall && arriving) |=> skid_valid_reg)
        else $error("finished result dropped while output held");

    // a frozen pipeline keeps its finishing valid bits
    a_frozen_pipeline: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(fin_valid_reg))
        else $error("pipeline moved while the skid entry was full");

    // the skid entry drains into the output once the receiver takes a result
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_stall) |=> (!skid_valid_reg && out_valid_reg))
        else $error("skid entry not drained after the output was taken");

endmodule

// File: tb/tb.sv
// self-checking testbench for the split-step phase rotator: random and corner-case requests
`timescale 1ns / 1ps

module tb;

    localparam int SW             = 24;
    localparam int STAGES         = 20;
    localparam int PIPE_LATENCY   = STAGES + 14;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_SETTINGS   = 6;

    // fixed-point constants of the rotation path
    localparam int          GUARD           = 24;
    localparam int          INTENSITY_SHIFT = 2 * (SW - 3) - 26;
    localparam logic [31:0] RAD_TO_TURNS    = 32'd683565276;
    localparam logic [31:0] INV_GAIN        = 32'h9B74_EDA8;
    localparam logic [31:0] LIN_STEP_INIT   = 32'd2147484;
    localparam logic [31:0] NL_STEP_INIT    = 32'd4294967;
    localparam logic [31:0] ARCTAN_TURNS [32] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
        32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
        32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
    };

    // rotation modes
    localparam logic MODE_LINEAR    = 1'b0;
    localparam logic MODE_NONLINEAR = 1'b1;

    // sample field extremes and unit magnitude
    localparam logic [SW-1:0] S_MAX  = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] S_MIN  = {1'b1, {(SW-1){1'b0}}};
    localparam logic [SW-1:0] S_ONE  = 24'h20_0000;
    localparam logic [SW-1:0] S_NEG1 = {SW{1'b1}};

    localparam int SETTING_ITEMS [NUM_SETTINGS] = '{200, 150, 225, 225, 225, 225};

    typedef struct packed {
        logic          mode;
        logic [SW-1:0] re;
        logic [SW-1:0] im;
        logic [23:0]   k2;
    } sample_req_t;

    typedef struct packed {
        logic [SW-1:0] re;
        logic [SW-1:0] im;
    } rotated_t;

    logic                 clk            = 1'b0;
    logic                 rst_n          = 1'b0;
    logic                 cfg_valid      = 1'b0;
    logic                 cfg_ready;
    logic [0:0]           cfg_index      = ssp_pkg::CFG_LINEAR_STEP;
    logic [31:0]          cfg_data       = '0;
    logic                 in_valid       = 1'b0;
    logic                 in_stall;
    logic                 mode           = MODE_LINEAR;
    logic signed [SW-1:0] sample_real    = '0;
    logic signed [SW-1:0] sample_imag    = '0;
    logic [23:0]          wave_number_sq = '0;
    logic                 out_valid;
    logic                 out_stall      = 1'b0;
    logic signed [SW-1:0] rotated_real;
    logic signed [SW-1:0] rotated_imag;

    // time steps as the block should hold them
    logic [31:0] linear_step    = LIN_STEP_INIT;
    logic [31:0] nonlinear_step = NL_STEP_INIT;

    sample_req_t pending_reqs[$];
    rotated_t    expected_rotations[$];
    sample_req_t cur_req;
    rotated_t    want;

    int unsigned tx_gap       = 0;
    int unsigned rx_hold      = 0;
    bit          tx_calm      = 1'b0;
    bit          rx_calm      = 1'b0;
    int unsigned idle_cycles  = 0;
    int unsigned errors       = 0;
    int unsigned reqs_sent    = 0;
    int unsigned linear_reqs  = 0;
    int unsigned results_seen = 0;
    int unsigned cfg_writes   = 0;

    split_step_phase_rotator #(
        .SAMPLE_WIDTH    (SW),
        .ROTATION_STAGES (STAGES)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .sample_real    (sample_real),
        .sample_imag    (sample_imag),
        .wave_number_sq (wave_number_sq),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .rotated_real   (rotated_real),
        .rotated_imag   (rotated_imag)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // round(a * b / 2^32), wrapping at 64 bits
    function automatic logic [63:0] scaled_product(input logic [63:0] a, input logic [31:0] b);
        logic [95:0] prod;
        prod = a * b;
        return prod[95:32] + {63'd0, prod[31]};
    endfunction

    // gain compensation, guard bit removal and saturation of one coordinate
    function automatic logic [SW-1:0] compensate_and_clip(input longint v);
        logic [63:0] mag;
        longint      r;
        logic        neg;
        neg = v < 0;
        mag = neg ? -v : v;
        mag = scaled_product(mag, INV_GAIN);
        mag = (mag + (64'd1 << (GUARD - 1))) >> GUARD;
        if (mag > (64'd1 << SW))
            mag = 64'd1 << SW;
        r = $signed(mag);
        if (neg)
            r = -r;
        if (r > $signed({1'b0, S_MAX}))
            r = $signed({1'b0, S_MAX});
        if (r < -$signed({1'b0, S_MAX}) - 1)
            r = -$signed({1'b0, S_MAX}) - 1;
        return r[SW-1:0];
    endfunction

    // expected rotated sample for one request under the current time steps
    function automatic rotated_t predict_rotation(input sample_req_t s);
        logic [63:0]       rad, ar, ai, pow, i26, lin, sq, mag, turns;
        logic [31:0]       phase, wrapped, resid;
        ssp_pkg::quarter_t quarter;
        longint            re, im, x, y, z, dx, dy, t;
        logic              neg;
        rotated_t          res;
        re = $signed(s.re);
        im = $signed(s.im);
        if (s.mode == MODE_LINEAR)
        begin
            rad   = scaled_product({24'd0, s.k2, 16'd0}, linear_step);
            turns = scaled_product(rad, RAD_TO_TURNS);
            phase = 32'd0 - turns[31:0];
        end
        else
        begin
            // intensity in Q6.26, then |psi|^2 - |psi|^4 as sign and magnitude
            ar  = (re < 0) ? -re : re;
            ai  = (im < 0) ? -im : im;
            pow = ar * ar + ai * ai;
            i26 = (pow + (64'd1 << (INTENSITY_SHIFT - 1))) >> INTENSITY_SHIFT;
            i26 = i26 & 64'hFFFF_FFFF;
            lin = i26 << 26;
            sq  = i26 * i26;
            neg = sq > lin;
            mag = neg ? sq - lin : lin - sq;
            mag = (mag + (64'd1 << 19)) >> 20;
            rad   = scaled_product(mag, nonlinear_step);
            turns = scaled_product(rad, RAD_TO_TURNS);
            phase = turns[31:0];
            if (neg)
                phase = 32'd0 - phase;
        end

        // exact quarter turn, residual within an eighth of a turn
        wrapped = phase + 32'h2000_0000;
        quarter = ssp_pkg::quarter_t'(wrapped[31:30]);
        resid   = phase - {wrapped[31:30], 30'd0};
        z       = $signed(resid);
        case (quarter)
            ssp_pkg::QUARTER_1:
            begin
                x = -im;
                y = re;
            end
            ssp_pkg::QUARTER_2:
            begin
                x = -re;
                y = -im;
            end
            ssp_pkg::QUARTER_3:
            begin
                x = im;
                y = -re;
            end
            default:
            begin
                x = re;
                y = im;
            end
        endcase
        x = x <<< GUARD;
        y = y <<< GUARD;

        // shift-and-add rotation cells
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                t = x - dx;
                y = y + dy;
                x = t;
                z = z - longint'(ARCTAN_TURNS[i]);
            end
            else
            begin
                t = x + dx;
                y = y - dy;
                x = t;
                z = z + longint'(ARCTAN_TURNS[i]);
            end
        end
        res.re = compensate_and_clip(x);
        res.im = compensate_and_clip(y);
        return res;
    endfunction

    function automatic sample_req_t make_req(input logic m, input logic [SW-1:0] re,
                                             input logic [SW-1:0] im, input logic [23:0] k2);
        sample_req_t r;
        r.mode = m;
        r.re   = re;
        r.im   = im;
        r.k2   = k2;
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_length();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return $urandom_range(1, 2);
        else if (pick < 92)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // sample part: extremes, values within unit magnitude, or anything
    function automatic logic [SW-1:0] random_component();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            case ($urandom_range(0, 4))
                0: return S_MAX;
                1: return S_MIN;
                2: return '0;
                3: return S_NEG1;
                default: return S_ONE;
            endcase
        end
        else if (pick < 45)
            return SW'($urandom_range(0, 32'h3F_FFFF) - 32'h20_0000);
        return SW'($urandom);
    endfunction

    function automatic sample_req_t random_request();
        logic [23:0] k2;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            case ($urandom_range(0, 3))
                0: k2 = 24'h00_0000;
                1: k2 = 24'hFF_FFFF;
                2: k2 = 24'h00_0001;
                default: k2 = 24'h80_0000;
            endcase
        end
        else if (pick < 40)
            k2 = 24'($urandom_range(0, 32'h0F_FFFF));
        else
            k2 = 24'($urandom);
        return make_req(($urandom_range(0, 1) != 0) ? MODE_NONLINEAR : MODE_LINEAR,
                        random_component(), random_component(), k2);
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        $display("tb: mismatch at %0t: %s", $time, what);
    endtask

    task automatic write_step(input ssp_pkg::cfg_index_t idx, input logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == ssp_pkg::CFG_LINEAR_STEP)
            linear_step = value;
        else
            nonlinear_step = value;
        cfg_writes++;
    endtask

    // wait for every request to come back, then let the pipeline empty
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || in_valid || expected_rotations.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 4) @(posedge clk);
    endtask

    // request driver with random gaps after accepted requests
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_rotations.push_back(predict_rotation(cur_req));
                reqs_sent++;
                if (cur_req.mode == MODE_LINEAR)
                    linear_reqs++;
                tx_gap = (!tx_calm && $urandom_range(0, 99) < 30) ? idle_length() : 0;
            end
            if ($urandom_range(0, 149) == 0)
                tx_calm = !tx_calm;
            if (!in_valid || !in_stall)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    cur_req = pending_reqs.pop_front();
                    in_valid       <= 1'b1;
                    mode           <= cur_req.mode;
                    sample_real    <= cur_req.re;
                    sample_imag    <= cur_req.im;
                    wave_number_sq <= cur_req.k2;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor and random output stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_rotations.size() == 0)
                    report_mismatch($sformatf("unexpected result %0d %0d",
                                              rotated_real, rotated_imag));
                else
                begin
                    want = expected_rotations.pop_front();
                    results_seen++;
                    if (rotated_real !== want.re)
                        report_mismatch($sformatf("real part %0d, expected %0d",
                                                  rotated_real, $signed(want.re)));
                    if (rotated_imag !== want.im)
                        report_mismatch($sformatf("imaginary part %0d, expected %0d",
                                                  rotated_imag, $signed(want.im)));
                end
            end
            if ($urandom_range(0, 149) == 0)
                rx_calm = !rx_calm;
            if (rx_hold > 0)
                rx_hold--;
            else if (!rx_calm && $urandom_range(0, 99) < 25)
                rx_hold = idle_length();
            out_stall <= (rx_hold > 0);
        end
    end

    // cycles without any handshake
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("tb: watchdog, no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("tb: done, errors");
        $finish;
    end

    // stimulus: one block of requests per time step setting
    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int setting = 0; setting < NUM_SETTINGS; setting++)
        begin
            if (setting > 0)
            begin
                wait_idle();
                case (setting)
                    1:
                    begin
                        // zero step: rotation only through cordic rounding
                        write_step(ssp_pkg::CFG_LINEAR_STEP, 32'd0);
                        write_step(ssp_pkg::CFG_NONLINEAR_STEP, 32'd0);
                    end
                    2:
                    begin
                        write_step(ssp_pkg::CFG_LINEAR_STEP, 32'hFFFF_FFFF);
                        write_step(ssp_pkg::CFG_NONLINEAR_STEP, 32'hFFFF_FFFF);
                    end
                    3:
                    begin
                        write_step(ssp_pkg::CFG_LINEAR_STEP, $urandom);
                        write_step(ssp_pkg::CFG_NONLINEAR_STEP, $urandom);
                    end
                    4:
                    begin
                        write_step(ssp_pkg::CFG_LINEAR_STEP, $urandom_range(0, 32'h00FF_FFFF));
                        write_step(ssp_pkg::CFG_NONLINEAR_STEP,
                                   $urandom_range(32'h1000_0000, 32'hFFFF_FFFF));
                    end
                    default:
                    begin
                        write_step(ssp_pkg::CFG_NONLINEAR_STEP, NL_STEP_INIT);
                        write_step(ssp_pkg::CFG_LINEAR_STEP, LIN_STEP_INIT);
                    end
                endcase
            end
            @(negedge clk);
            if (setting == 0)
            begin
                // corner cases at the reset time steps
                pending_reqs.push_back(make_req(MODE_LINEAR, S_MAX, '0, 24'h00_0000));
                pending_reqs.push_back(make_req(MODE_LINEAR, S_MIN, S_MIN, 24'h00_0000));
                pending_reqs.push_back(make_req(MODE_LINEAR, S_MAX, S_MAX, 24'hFF_FFFF));
                pending_reqs.push_back(make_req(MODE_LINEAR, S_MIN, S_MAX, 24'hFF_FFFF));
                pending_reqs.push_back(make_req(MODE_LINEAR, S_ONE, '0, 24'h00_0001));
                pending_reqs.push_back(make_req(MODE_LINEAR, S_NEG1, S_NEG1, 24'h80_0000));
                pending_reqs.push_back(make_req(MODE_LINEAR, '0, '0, 24'hFF_FFFF));
                pending_reqs.push_back(make_req(MODE_LINEAR, S_MAX, S_MIN, 24'h01_0000));
                pending_reqs.push_back(make_req(MODE_LINEAR, S_MIN, '0, 24'h00_0001));
                pending_reqs.push_back(make_req(MODE_NONLINEAR, '0, '0, 24'h00_0000));
                pending_reqs.push_back(make_req(MODE_NONLINEAR, S_MAX, S_MAX, 24'hFF_FFFF));
                pending_reqs.push_back(make_req(MODE_NONLINEAR, S_MIN, S_MIN, 24'h00_0000));
                pending_reqs.push_back(make_req(MODE_NONLINEAR, S_MIN, '0, 24'h12_3456));
                pending_reqs.push_back(make_req(MODE_NONLINEAR, S_MAX, '0, 24'h00_0000));
                // unit magnitude: intensity term cancels
                pending_reqs.push_back(make_req(MODE_NONLINEAR, S_ONE, '0, 24'h5A_5A5A));
                pending_reqs.push_back(make_req(MODE_NONLINEAR, '0, -S_ONE, 24'hA5_A5A5));
                pending_reqs.push_back(make_req(MODE_NONLINEAR, 24'h16_A09E, 24'h16_A09E,
                                                24'h00_0000));
                // below and above unit magnitude
                pending_reqs.push_back(make_req(MODE_NONLINEAR, 24'h10_0000, '0, 24'h00_0000));
                pending_reqs.push_back(make_req(MODE_NONLINEAR, 24'h30_0000, '0, 24'hFF_FFFF));
                pending_reqs.push_back(make_req(MODE_NONLINEAR, 24'h00_0001, S_NEG1,
                                                24'h00_0000));
            end
            repeat (SETTING_ITEMS[setting])
                pending_reqs.push_back(random_request());
        end
        wait_idle();
        if (expected_rotations.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_rotations.size()));
        $display("tb: %0d samples rotated (%0d linear, %0d nonlinear), %0d results compared",
                 reqs_sent, linear_reqs, reqs_sent - linear_reqs, results_seen);
        $display("tb: %0d step writes over %0d settings, %0d mismatches",
                 cfg_writes, NUM_SETTINGS, errors);
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
